[hdl/ght_pkg.sv]
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// Command classes, status codes, queue sizing and the records passed between
// the front part, the command queue and the back part.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int COUNT_W    = $clog2(SLOTS + 1);
  localparam int WORD_W     = 32;
  localparam int OPCODE_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int ROW_W      = 2 * WORD_W;

  // command queue depth, a power of two so the pointers wrap on their own
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [OPCODE_W-1:0] OP_BIND    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_FORGET  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REVERSE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_ENUM    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_BIND    = 3'd0,
    K_FORGET  = 3'd1,
    K_LOOKUP  = 3'd2,
    K_REVERSE = 3'd3,
    K_ENUM    = 3'd4,
    K_CLEAR   = 3'd5,
    K_BAD     = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic                null_owner;
    logic                in_range;
    logic [SLOT_W-1:0]   slot;
    logic [WORD_W-1:0]   generation;
    logic [WORD_W-1:0]   owner;
  } cmd_t;

  typedef struct packed {
    status_t                 status;
    logic [WORD_W-1:0]       owner;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [WORD_W-1:0]       generation;
    logic [COUNT_OUT_W-1:0]  count;
    logic                    last;
  } result_t;

endpackage

[hdl/ght_ram.sv]
// ----------------------------------------------------------------------------
// ght_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data holds while no read is issued.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/ght_front.sv]
// ----------------------------------------------------------------------------
// ght_front: input acceptance and classification
// Decodes the opcode, checks the owner for null and the slot for range, and
// pushes a compact command into the queue.
// ----------------------------------------------------------------------------
module ght_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ght_pkg::OPCODE_W-1:0] opcode,
  input  logic [ght_pkg::WORD_W-1:0]   slot_index,
  input  logic [ght_pkg::WORD_W-1:0]   generation_tag,
  input  logic [ght_pkg::WORD_W-1:0]   owner_id,
  input  logic                      q_full,
  output logic                      push,
  output ght_pkg::cmd_t             push_cmd
);
  import ght_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd.null_owner = (owner_id == '0);
    push_cmd.in_range   = (slot_index < WORD_W'(SLOTS));
    push_cmd.slot       = slot_index[SLOT_W-1:0];
    push_cmd.generation = generation_tag;
    push_cmd.owner      = owner_id;
    unique case (opcode)
      OP_BIND:    push_cmd.kind = K_BIND;
      OP_FORGET:  push_cmd.kind = K_FORGET;
      OP_LOOKUP:  push_cmd.kind = K_LOOKUP;
      OP_REVERSE: push_cmd.kind = K_REVERSE;
      OP_ENUM:    push_cmd.kind = K_ENUM;
      OP_CLEAR:   push_cmd.kind = K_CLEAR;
      default:    push_cmd.kind = K_BAD;
    endcase
  end

endmodule

[hdl/ght_queue.sv]
// ----------------------------------------------------------------------------
// ght_queue: short command queue
// Decouples the front part from the back part; QDEPTH entries of cmd_t.
// ----------------------------------------------------------------------------
module ght_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ght_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output ght_pkg::cmd_t head
);
  import ght_pkg::*;

  cmd_t               entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign full      = (fill == QCNT_W'(QDEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[hdl/ght_back.sv]
// ----------------------------------------------------------------------------
// ght_back: command execution
// Holds the bound bits and live count, drives the row RAM, walks the rows for
// reverse lookup and enumerate, and owns the output register.
// ----------------------------------------------------------------------------
module ght_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  ght_pkg::cmd_t    q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output ght_pkg::result_t out_res
);
  import ght_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_CMP      = 4'b0010,
    S_SCAN_RD  = 4'b0100,
    S_SCAN_CHK = 4'b1000
  } state_t;

  state_t             state, state_next;
  cmd_t               cmd;
  logic [SLOTS-1:0]   bound, bound_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [SLOT_W-1:0]  ptr, ptr_next;
  logic               out_free;
  logic               emit;
  result_t            res;
  logic               more;
  logic               ptr_last;

  logic               ram_we;
  logic               ram_re;
  logic [SLOT_W-1:0]  ram_addr;
  logic [ROW_W-1:0]   ram_wdata;
  logic [ROW_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]  rd_gen;
  logic [WORD_W-1:0]  rd_owner;

  assign rd_gen   = ram_rdata[ROW_W-1:WORD_W];
  assign rd_owner = ram_rdata[WORD_W-1:0];
  assign out_free = !out_valid || out_ready;
  assign ptr_last = (ptr == SLOT_W'(SLOTS - 1));

  // any bound row above the current scan position
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if ((SLOT_W'(j) > ptr) && bound[j]) begin
        more = 1'b1;
      end
    end
  end

  ght_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SLOTS)
  ) u_rows (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    bound_next = bound;
    count_next = count;
    ptr_next   = ptr;
    pop        = 1'b0;
    emit       = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = q_head.slot;
    ram_wdata  = {q_head.generation, q_head.owner};
    res.status     = ST_OK;
    res.owner      = '0;
    res.slot       = '0;
    res.generation = '0;
    res.last       = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          unique case (q_head.kind)
            K_BIND: begin
              emit = 1'b1;
              if (q_head.null_owner) begin
                res.status = ST_NULL;
              end else if (!q_head.in_range) begin
                res.status = ST_RANGE;
              end else begin
                ram_we = 1'b1;
                bound_next[q_head.slot] = 1'b1;
                if (!bound[q_head.slot]) begin
                  count_next = count + 1'b1;
                end
              end
            end
            K_FORGET, K_LOOKUP: begin
              if (!q_head.in_range) begin
                emit       = 1'b1;
                res.status = ST_RANGE;
              end else if (!bound[q_head.slot]) begin
                emit       = 1'b1;
                res.status = ST_MISS;
              end else begin
                ram_re     = 1'b1;
                state_next = S_CMP;
              end
            end
            K_REVERSE: begin
              if (q_head.null_owner) begin
                emit       = 1'b1;
                res.status = ST_NULL;
              end else begin
                ptr_next   = '0;
                state_next = S_SCAN_RD;
              end
            end
            K_ENUM: begin
              ptr_next   = '0;
              state_next = S_SCAN_RD;
            end
            K_CLEAR: begin
              emit       = 1'b1;
              bound_next = '0;
              count_next = '0;
            end
            default: begin
              emit       = 1'b1;
              res.status = ST_MISS;
            end
          endcase
        end
      end

      S_CMP: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (rd_gen != cmd.generation) begin
            res.status = ST_MISS;
          end else if (cmd.kind == K_FORGET) begin
            bound_next[cmd.slot] = 1'b0;
            count_next = count - 1'b1;
          end else begin
            res.owner = rd_owner;
          end
        end
      end

      S_SCAN_RD: begin
        ram_addr = ptr;
        if (bound[ptr]) begin
          ram_re     = 1'b1;
          state_next = S_SCAN_CHK;
        end else if (ptr_last) begin
          // walked off the end without a hit
          if (out_free) begin
            emit       = 1'b1;
            res.status = ST_MISS;
            state_next = S_IDLE;
          end
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      S_SCAN_CHK: begin
        ram_addr = ptr;
        if (cmd.kind == K_REVERSE) begin
          if (rd_owner == cmd.owner) begin
            if (out_free) begin
              emit           = 1'b1;
              res.owner      = rd_owner;
              res.slot       = SLOT_OUT_W'(ptr);
              res.generation = rd_gen;
              state_next     = S_IDLE;
            end
          end else if (ptr_last) begin
            if (out_free) begin
              emit       = 1'b1;
              res.status = ST_MISS;
              state_next = S_IDLE;
            end
          end else begin
            ptr_next   = ptr + 1'b1;
            state_next = S_SCAN_RD;
          end
        end else begin
          if (out_free) begin
            emit           = 1'b1;
            res.owner      = rd_owner;
            res.slot       = SLOT_OUT_W'(ptr);
            res.generation = rd_gen;
            res.last       = !more;
            if (more) begin
              ptr_next   = ptr + 1'b1;
              state_next = S_SCAN_RD;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.count = COUNT_OUT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bound     <= '0;
      count     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      bound <= bound_next;
      count <= count_next;
      ptr   <= ptr_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_head;
    end
    if (emit) begin
      out_res <= res;
    end
  end

endmodule

[hdl/generational_handle_table_top.sv]
// ----------------------------------------------------------------------------
// generational_handle_table_top: generational slot map with live row count
// Bind, forget, lookup, reverse lookup, enumerate and clear over SLOTS rows.
// ----------------------------------------------------------------------------
// Order: bind, clear, rejected and unknown commands are answered from the idle
//   state once popped from the queue; forget and lookup first read the row RAM.
// Throughput: one command per cycle (bind, clear) while the output is not
//   stalled; forget and lookup hold the back part until the compare in S_CMP is done; scans walk the rows one by one.
// Reset: bound bits, live count, queue pointers, back part state and output
//   valid flag clear; row contents are not cleared, so no clearing pass runs.
module generational_handle_table_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ght_pkg::OPCODE_W-1:0]    opcode,
  input  logic [ght_pkg::WORD_W-1:0]      slot_index,
  input  logic [ght_pkg::WORD_W-1:0]      generation_tag,
  input  logic [ght_pkg::WORD_W-1:0]      owner_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ght_pkg::STATUS_W-1:0]    status,
  output logic [ght_pkg::WORD_W-1:0]      owner_out,
  output logic [ght_pkg::SLOT_OUT_W-1:0]  slot_out,
  output logic [ght_pkg::WORD_W-1:0]      generation_out,
  output logic [ght_pkg::COUNT_OUT_W-1:0] live_count,
  output logic                            last
);
  import ght_pkg::*;

  logic    q_full;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  logic    q_valid;
  cmd_t    q_head;
  result_t out_res;

  ght_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .slot_index    (slot_index),
    .generation_tag(generation_tag),
    .owner_id      (owner_id),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  ght_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  ght_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign status         = out_res.status;
  assign owner_out      = out_res.owner;
  assign slot_out       = out_res.slot;
  assign generation_out = out_res.generation;
  assign live_count     = out_res.count;
  assign last           = out_res.last;

endmodule

[bench/generational_handle_table_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_handle_table_top_tb: self-checking bench for the handle table
// Sends bind, forget, lookup, reverse lookup, enumerate, clear and unknown
// commands. A mirror of the table works out the replies of every accepted
// command. Each reply transfer is checked field by field against the oldest
// one still owed. Directed cases run first, then a full table, then random
// traffic under several sender gap and receiver stall mixes.
// ----------------------------------------------------------------------------
module generational_handle_table_top_tb;
  import ght_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 200;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OPCODE_W-1:0]    opcode = '0;
  logic [WORD_W-1:0]      slot_index = '0;
  logic [WORD_W-1:0]      generation_tag = '0;
  logic [WORD_W-1:0]      owner_id = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [WORD_W-1:0]      owner_out;
  logic [SLOT_OUT_W-1:0]  slot_out;
  logic [WORD_W-1:0]      generation_out;
  logic [COUNT_OUT_W-1:0] live_count;
  logic                   last;

  // mirror of the table
  logic                   row_live [SLOTS];
  logic                   row_touched [SLOTS];
  logic [WORD_W-1:0]      row_gen [SLOTS];
  logic [WORD_W-1:0]      row_own [SLOTS];
  logic [COUNT_OUT_W-1:0] live_rows;

  result_t     table_replies [$];
  result_t     owed;
  int          error_count = 0;
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;

  generational_handle_table_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .slot_index     (slot_index),
    .generation_tag (generation_tag),
    .owner_id       (owner_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .owner_out      (owner_out),
    .slot_out       (slot_out),
    .generation_out (generation_out),
    .live_count     (live_count),
    .last           (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies still owed", cycle_count,
               table_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Work out the replies of one accepted command and update the mirror.
  task automatic model_table_op(input logic [OPCODE_W-1:0] op,
                                input logic [WORD_W-1:0] idx,
                                input logic [WORD_W-1:0] gen,
                                input logic [WORD_W-1:0] own);
    result_t r;
    bit      single;
    int      n;
    r = '0;
    r.last = 1'b1;
    single = 1'b1;
    n = 0;
    case (op)
      OP_BIND: begin
        if (own == '0) r.status = ST_NULL;
        else if (idx >= SLOTS) r.status = ST_RANGE;
        else begin
          if (!row_live[idx]) live_rows = live_rows + 1'b1;
          row_live[idx] = 1'b1;
          row_touched[idx] = 1'b1;
          row_gen[idx] = gen;
          row_own[idx] = own;
          r.status = ST_OK;
        end
      end
      OP_FORGET: begin
        if (idx >= SLOTS) r.status = ST_RANGE;
        else if (!row_live[idx] || row_gen[idx] != gen) r.status = ST_MISS;
        else begin
          row_live[idx] = 1'b0;
          row_own[idx] = '0;
          if (live_rows != 0) live_rows = live_rows - 1'b1;
          r.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (idx >= SLOTS) r.status = ST_RANGE;
        else if (!row_live[idx] || row_gen[idx] != gen) r.status = ST_MISS;
        else begin
          r.status = ST_OK;
          r.owner = row_own[idx];
        end
      end
      OP_REVERSE: begin
        if (own == '0) r.status = ST_NULL;
        else begin
          r.status = ST_MISS;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            // walk downward so the lowest matching slot wins
            if (row_live[i] && row_own[i] == own) begin
              r.status = ST_OK;
              r.owner = own;
              r.slot = SLOT_OUT_W'(i);
              r.generation = row_gen[i];
            end
          end
        end
      end
      OP_ENUM: begin
        r.status = ST_MISS;
        for (int i = 0; i < SLOTS; i++) begin
          if (row_live[i]) begin
            n++;
            single = 1'b0;
            r.status = ST_OK;
            r.owner = row_own[i];
            r.slot = SLOT_OUT_W'(i);
            r.generation = row_gen[i];
            r.count = live_rows;
            r.last = (n == live_rows);
            table_replies.push_back(r);
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          row_live[i] = 1'b0;
          row_gen[i] = '0;
          row_own[i] = '0;
        end
        live_rows = '0;
        r.status = ST_OK;
      end
      default: r.status = ST_MISS;
    endcase
    if (single) begin
      r.count = live_rows;
      table_replies.push_back(r);
    end
  endtask

  // Present one command, hold it until the transfer, then record its replies.
  task automatic send_cmd(input logic [OPCODE_W-1:0] op,
                          input logic [WORD_W-1:0] idx,
                          input logic [WORD_W-1:0] gen,
                          input logic [WORD_W-1:0] own);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    slot_index <= idx;
    generation_tag <= gen;
    owner_id <= own;
    do @(posedge clk); while (!in_ready);
    model_table_op(op, idx, gen, own);
  endtask

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (table_replies.size() == 0) begin
        $display("%0t ns: reply with none owed, expected nothing, actual status %0d owner 0x%0h",
                 $time, status, owner_out);
        error_count++;
      end else begin
        owed = table_replies.pop_front();
        check_field("status", owed.status, status);
        check_field("owner_out", owed.owner, owner_out);
        check_field("slot_out", owed.slot, slot_out);
        check_field("generation_out", owed.generation, generation_out);
        check_field("live_count", owed.count, live_count);
        check_field("last", owed.last, last);
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // First row from start (wrapping) that is live, or merely written once.
  function automatic int pick_written_row(input int start, input bit need_live);
    int j;
    for (int k = 0; k < SLOTS; k++) begin
      j = (start + k) % SLOTS;
      if (need_live ? row_live[j] : row_touched[j]) return j;
    end
    return -1;
  endfunction

  task automatic test_empty_table();
    send_cmd(OP_ENUM, 32'h0, 32'h0, 32'h0);
    send_cmd(OP_REVERSE, 32'h0, 32'h0, 32'h5);
  endtask

  task automatic test_bind_rejects();
    send_cmd(OP_BIND, 32'd3, 32'd1, 32'h0);
    send_cmd(OP_BIND, 32'd64, 32'd1, 32'h1);
    send_cmd(OP_BIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_bind_lookup();
    send_cmd(OP_BIND, 32'd0, 32'h0, 32'hFFFF_FFFF);
    send_cmd(OP_BIND, 32'd63, 32'hFFFF_FFFF, 32'h1);
    // rebind of a live row keeps the count
    send_cmd(OP_BIND, 32'd0, 32'd7, 32'hAAAA_5555);
    send_cmd(OP_LOOKUP, 32'd0, 32'd7, 32'h0);
    send_cmd(OP_LOOKUP, 32'd0, 32'h0, 32'h0);
    send_cmd(OP_LOOKUP, 32'd64, 32'd7, 32'h0);
  endtask

  task automatic test_scans();
    send_cmd(OP_BIND, 32'd10, 32'd3, 32'h1);
    send_cmd(OP_REVERSE, 32'h0, 32'h0, 32'h1);
    send_cmd(OP_REVERSE, 32'h0, 32'h0, 32'h0);
    send_cmd(OP_REVERSE, 32'h0, 32'h0, 32'h0001_2345);
    send_cmd(OP_ENUM, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_forget();
    send_cmd(OP_FORGET, 32'd0, 32'h0, 32'h0);
    send_cmd(OP_FORGET, 32'd0, 32'd7, 32'h0);
    send_cmd(OP_FORGET, 32'd0, 32'd7, 32'h0);
    send_cmd(OP_LOOKUP, 32'd0, 32'd7, 32'h0);
    send_cmd(OP_FORGET, 32'hFFFF_FFFF, 32'd7, 32'h0);
  endtask

  task automatic test_unknown_and_clear();
    send_cmd(OP_SPARE_LO, 32'd10, 32'd3, 32'h1);
    send_cmd(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(OP_CLEAR, 32'h0, 32'h0, 32'h0);
    send_cmd(OP_ENUM, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++) send_cmd(OP_BIND, i, $urandom(), $urandom_range(40, 1));
    send_cmd(OP_ENUM, 32'h0, 32'h0, 32'h0);
    send_cmd(OP_REVERSE, 32'h0, 32'h0, row_own[SLOTS-1]);
    send_cmd(OP_LOOKUP, SLOTS - 1, row_gen[SLOTS-1], 32'h0);
    send_cmd(OP_CLEAR, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_random_traffic(input int count);
    logic [OPCODE_W-1:0] op;
    logic [WORD_W-1:0]   idx;
    logic [WORD_W-1:0]   gen;
    logic [WORD_W-1:0]   own;
    int                  pick;
    int                  s;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 32) op = OP_BIND;
      else if (pick < 52) op = OP_FORGET;
      else if (pick < 70) op = OP_LOOKUP;
      else if (pick < 84) op = OP_REVERSE;
      else if (pick < 92) op = OP_ENUM;
      else if (pick < 95) op = OP_CLEAR;
      else op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      idx = $urandom_range(SLOTS - 1);
      gen = $urandom();
      own = $urandom();
      if ($urandom_range(9) == 0) gen = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      case (op)
        OP_BIND: begin
          pick = $urandom_range(99);
          if (pick < 5) own = '0;
          else if (pick < 55) own = $urandom_range(6, 1);
        end
        OP_FORGET, OP_LOOKUP: begin
          // stay on rows that were written at least once, or go out of range if none were
          s = pick_written_row(int'(idx), $urandom_range(99) < 75);
          if (s < 0) s = pick_written_row(int'(idx), 1'b0);
          if (s < 0) idx = 32'h0000_0040;
          else begin
            idx = s;
            if ($urandom_range(99) < 70) gen = row_gen[s];
          end
        end
        OP_REVERSE: begin
          pick = $urandom_range(99);
          if (pick < 6) own = '0;
          else if (pick < 50) own = $urandom_range(6, 1);
          else if (pick < 75) begin
            s = pick_written_row($urandom_range(SLOTS - 1), 1'b1);
            if (s >= 0) own = row_own[s];
          end
        end
        default: ;
      endcase
      if ($urandom_range(99) < 10) idx = $urandom() | (32'h1 << $urandom_range(31, 6));
      send_cmd(op, idx, gen, own);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      row_live[i] = 1'b0;
      row_touched[i] = 1'b0;
      row_gen[i] = '0;
      row_own[i] = '0;
    end
    live_rows = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_bind_rejects();
    test_bind_lookup();
    test_scans();
    test_forget();
    test_unknown_and_clear();

    send_gap_pct = 37;
    stall_pct = 37;
    test_full_table();

    send_gap_pct = 0;
    stall_pct = 0;
    test_random_traffic(36);
    send_gap_pct = 80;
    stall_pct = 0;
    test_random_traffic(36);
    send_gap_pct = 0;
    stall_pct = 80;
    test_random_traffic(36);
    send_gap_pct = 37;
    stall_pct = 37;
    test_random_traffic(36);

    in_valid <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && table_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
